>>> rtl/fcb_pkg.sv
// ----------------------------------------------------------------------------
// fcb_pkg
// Shared constants, types and tables for the first-fit conflict batcher.
// ----------------------------------------------------------------------------
package fcb_pkg;

    localparam int MAX_BATCHES = 16;
    localparam int KEY_IDS     = 64;

    localparam int IDX_W    = $clog2(MAX_BATCHES);
    localparam int CNT_W    = $clog2(MAX_BATCHES + 1);
    localparam int KEY_W    = $clog2(KEY_IDS);
    localparam int KEY_IN_W = 6;
    localparam int BI_W     = 4;

    localparam int IN_DATA_W  = ((2 + KEY_IN_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((BI_W + 2 + 7) / 8) * 8;

    typedef logic [KEY_IDS-1:0] t_row;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [KEY_W-1:0]   t_key;

    typedef struct packed {
        logic                first_of_list;
        logic                parallelizable;
        logic                has_key;
        logic [KEY_IN_W-1:0] key_id;
    } t_job;

    typedef struct packed {
        logic            overflow;
        logic            opened_new;
        logic [BI_W-1:0] batch_index;
    } t_res;

    typedef struct packed {
        logic en;
        t_idx addr;
        logic excl;
        t_row row;
    } t_wr;

    typedef struct packed {
        logic excl;
        t_row row;
    } t_rd;

    typedef t_key t_fold [2**KEY_IN_W];

    function automatic t_fold build_fold();
        t_fold f;
        for (int i = 0; i < 2**KEY_IN_W; i++) begin
            f[i] = t_key'(i % KEY_IDS);
        end
        return f;
    endfunction

    localparam t_fold KEY_FOLD = build_fold();

endpackage

>>> rtl/fcb_batch_store.sv
// ----------------------------------------------------------------------------
// fcb_batch_store
// Batch table: per-batch key bitmap and exclusive flag, one write port and
// one registered read port.
// ----------------------------------------------------------------------------
module fcb_batch_store (
    input  logic         i_clk,
    input  fcb_pkg::t_wr i_wr,
    input  fcb_pkg::t_idx i_rd_addr,
    output fcb_pkg::t_rd o_rd
);
    import fcb_pkg::*;

    t_row                   r_key_map [MAX_BATCHES];
    logic [MAX_BATCHES-1:0] r_excl;
    t_rd                    r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_key_map[i_wr.addr] <= i_wr.row;
            r_excl[i_wr.addr]    <= i_wr.excl;
        end
        r_rd.row  <= r_key_map[i_rd_addr];
        r_rd.excl <= r_excl[i_rd_addr];
    end

    assign o_rd = r_rd;

endmodule

>>> rtl/fcb_sequencer.sv
// ----------------------------------------------------------------------------
// fcb_sequencer
// Scan sequencer: walks the open batches one per cycle through the shared
// fit check, then records any placed job and loads the result register.
// ----------------------------------------------------------------------------
module fcb_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  fcb_pkg::t_job i_job,
    output logic          o_job_ready,
    input  logic          i_par_en,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output fcb_pkg::t_res o_res,
    output fcb_pkg::t_wr  o_wr,
    output fcb_pkg::t_idx o_rd_addr,
    input  fcb_pkg::t_rd  i_rd
);
    import fcb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state;
    t_cnt   r_count;
    t_idx   r_idx;
    t_idx   r_target;
    logic   r_found;
    t_row   r_row;
    logic   r_has_key;
    t_key   r_key;
    logic   r_mode;
    logic   r_res_valid;
    t_res   r_res;

    t_row   key_bit;
    logic   fit;
    logic   out_free;
    logic   full;
    logic   mode_in;
    t_cnt   cnt_eff;
    t_cnt   idx_inc;
    t_res   n_res;

    function automatic logic [BI_W-1:0] to_bi(input t_cnt v);
        logic [CNT_W+BI_W-1:0] e;
        e = {{BI_W{1'b0}}, v};
        return e[BI_W-1:0];
    endfunction

    always_comb begin
        key_bit  = r_has_key ? (t_row'(1) << r_key) : '0;
        fit      = !i_rd.excl && ((i_rd.row & key_bit) == '0);
        out_free = !r_res_valid || i_res_ready;
        full     = r_count >= t_cnt'(MAX_BATCHES);
        mode_in  = i_job.parallelizable && i_par_en;
        cnt_eff  = i_job.first_of_list ? '0 : r_count;
        idx_inc  = t_cnt'(r_idx) + t_cnt'(1);

        priority if (r_found) begin
            n_res.batch_index = to_bi(t_cnt'(r_target));
            n_res.opened_new  = 1'b0;
            n_res.overflow    = 1'b0;
        end else if (full) begin
            n_res.batch_index = '0;
            n_res.opened_new  = 1'b0;
            n_res.overflow    = 1'b1;
        end else begin
            n_res.batch_index = to_bi(r_count);
            n_res.opened_new  = 1'b1;
            n_res.overflow    = 1'b0;
        end

        o_wr.en   = (r_state == S_DONE) && out_free && (r_found || !full);
        o_wr.addr = r_found ? r_target : t_idx'(r_count);
        o_wr.excl = !r_mode;
        o_wr.row  = r_found ? (r_row | key_bit) : key_bit;

        o_rd_addr = (r_state == S_SCAN) ? t_idx'(r_idx + 1'b1) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_res_valid <= 1'b1;
            end else if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_has_key <= i_job.has_key;
                        r_key     <= KEY_FOLD[i_job.key_id];
                        r_mode    <= mode_in;
                        r_found   <= 1'b0;
                        r_idx     <= '0;
                        r_count   <= cnt_eff;
                        if (mode_in && (cnt_eff != '0)) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    if (fit) begin
                        r_found  <= 1'b1;
                        r_target <= r_idx;
                        r_row    <= i_rd.row;
                        r_state  <= S_DONE;
                    end else if (idx_inc == r_count) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= t_idx'(r_idx + 1'b1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_res <= n_res;
                        if (!r_found && !full) begin
                            r_count <= r_count + t_cnt'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_job_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

>>> rtl/first_fit_conflict_batcher.sv
// ----------------------------------------------------------------------------
// first_fit_conflict_batcher
// First-fit job batcher with per-batch conflict keys.
// ----------------------------------------------------------------------------
// Jobs arrive on the s_axis channel, one transaction per job; the batch
// assignment leaves on m_axis, one transaction per job, in order.
// The cfg channel writes parallel_enable and is always ready; write it only
// while no job is in flight.
// A parallelizable job in parallel mode is checked against the open batches
// one per cycle in the shared fit unit, reading the batch table through its
// single registered read port. The scan covers 1 to MAX_BATCHES batches and
// stops at the first fit; the sequencer then goes to its done state, which
// loads the result register. Other jobs go from acceptance straight to the
// done state. s_axis_tready is high only while the sequencer is idle, so one
// job is in work at a time.
// The result register holds a finished transaction while m_axis stalls, and
// the next job is accepted meanwhile; it waits to record only if the
// previous result is still untaken.
// Reset empties the batch table (count to zero), drops any pending result
// and sets parallel_enable to 1. No clearing pass is needed.
// ----------------------------------------------------------------------------
module first_fit_conflict_batcher (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // parallelizable, has_key, key_id[5:0]
    input  logic [fcb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // first_of_list
    input  logic [0:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // batch_index[3:0], opened_new, overflow, zero pad
    output logic [fcb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [0:0]                     i_cfg_data
);
    import fcb_pkg::*;

    logic r_par_en;
    t_job job;
    t_res res;
    t_wr  wr;
    t_rd  rd;
    t_idx rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_par_en <= i_cfg_data[0];
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        job.first_of_list  = s_axis_tuser[0];
        job.parallelizable = s_axis_tdata[0];
        job.has_key        = s_axis_tdata[1];
        job.key_id         = s_axis_tdata[2 +: KEY_IN_W];
    end

    fcb_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (s_axis_tvalid),
        .i_job       (job),
        .o_job_ready (s_axis_tready),
        .i_par_en    (r_par_en),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res),
        .o_wr        (wr),
        .o_rd_addr   (rd_addr),
        .i_rd        (rd)
    );

    fcb_batch_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (rd_addr),
        .o_rd      (rd)
    );

    assign m_axis_tdata = OUT_DATA_W'(res);

endmodule

>>> rtl/fcb_checker.sv
// ----------------------------------------------------------------------------
// fcb_checker
// Port-level checks for the first-fit conflict batcher, bound to the top.
// ----------------------------------------------------------------------------
module fcb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic [fcb_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [0:0]                     s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [fcb_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [0:0]                     i_cfg_data
);

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("outputs not idle after reset");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready straight after a transaction");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_overflow_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) && m_axis_tdata[5] |-> m_axis_tdata[4:0] == 5'd0)
        else $error("overflow result carries an index or open flag");

endmodule

bind first_fit_conflict_batcher fcb_checker u_fcb_checker (.*);

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit conflict batcher.
// Jobs go in on the slave stream and placements come back on the master
// stream. A model of the batch table, kept in step with every accepted job and
// every mode write, predicts each placement, and the bench compares it field
// by field in order. Directed lists cover key conflicts, exclusive batches,
// a full table and parallel mode off. Random lists follow, with random gaps and
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fcb_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [3:0] batch_index;
        logic       opened_new;
        logic       overflow;
    } t_placement;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [0:0]            i_cfg_data = '0;

    // table model
    bit                 parallel_on = 1'b1;
    int                 open_batches = 0;
    bit                 batch_excl [MAX_BATCHES];
    logic [KEY_IDS-1:0] batch_keys [MAX_BATCHES];

    t_placement placements_due [$];
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         rx_hold = 0;
    bit         gaps_on = 1'b1;
    bit         stalls_on = 1'b1;
    t_placement got;
    t_placement want;

    first_fit_conflict_batcher dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int draw_wait(bit on);
        return on ? int'($urandom_range(0, 13)) : 0;
    endfunction

    function automatic void clear_table();
        open_batches = 0;
        for (int i = 0; i < MAX_BATCHES; i++) begin
            batch_excl[i] = 1'b0;
            batch_keys[i] = '0;
        end
    endfunction

    function automatic t_placement place_job(bit first, bit par, bit has_key,
                                             logic [KEY_IN_W-1:0] key);
        t_placement         p;
        logic [KEY_IDS-1:0] key_bit;
        int                 slot;
        slot = -1;
        p = '0;
        key_bit = has_key ? (KEY_IDS'(1) << (key % KEY_IDS)) : '0;
        if (first) begin
            clear_table();
        end
        if (par && parallel_on) begin
            for (int i = 0; i < open_batches; i++) begin
                if (slot < 0 && !batch_excl[i] && (batch_keys[i] & key_bit) == '0) begin
                    slot = i;
                end
            end
        end
        if (slot >= 0) begin
            batch_keys[slot] |= key_bit;
            p.batch_index = 4'(slot);
        end else if (open_batches >= MAX_BATCHES) begin
            p.overflow = 1'b1;
        end else begin
            batch_keys[open_batches] = key_bit;
            batch_excl[open_batches] = !par || !parallel_on;
            p.batch_index = 4'(open_batches);
            p.opened_new = 1'b1;
            open_batches++;
        end
        return p;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic send_job(bit first, bit par, bit has_key, logic [KEY_IN_W-1:0] key);
        int gap;
        gap = draw_wait(gaps_on);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({key, has_key, par});
        s_axis_tuser  <= first;
        do @(posedge i_clk); while (!s_axis_tready);
        placements_due.push_back(place_job(first, par, has_key, key));
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (placements_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_parallel(bit on);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= on;
        do @(posedge i_clk); while (!o_cfg_ready);
        parallel_on = on;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_placement'({m_axis_tdata[3:0], m_axis_tdata[4], m_axis_tdata[5]});
                if (placements_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected placement %p", got));
                end else begin
                    want = placements_due.pop_front();
                    if (got.batch_index !== want.batch_index)
                        report_mismatch($sformatf("batch_index %0d, want %0d",
                                                  got.batch_index, want.batch_index));
                    if (got.opened_new !== want.opened_new)
                        report_mismatch($sformatf("opened_new %b, want %b",
                                                  got.opened_new, want.opened_new));
                    if (got.overflow !== want.overflow)
                        report_mismatch($sformatf("overflow %b, want %b",
                                                  got.overflow, want.overflow));
                end
                rx_hold = draw_wait(stalls_on);
            end else if (rx_hold > 0) begin
                rx_hold--;
            end
            m_axis_tready <= (rx_hold == 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic test_first_fit_keys();
        send_job(1'b1, 1'b1, 1'b0, 6'd0);
        send_job(1'b0, 1'b1, 1'b1, 6'd0);
        send_job(1'b0, 1'b1, 1'b1, 6'd0);
        send_job(1'b0, 1'b1, 1'b1, 6'd63);
        send_job(1'b0, 1'b1, 1'b0, 6'd63);
        send_job(1'b0, 1'b0, 1'b1, 6'd5);
        send_job(1'b0, 1'b1, 1'b1, 6'd0);
        send_job(1'b0, 1'b1, 1'b1, 6'd42);
        send_job(1'b0, 1'b1, 1'b1, 6'd21);
        send_job(1'b1, 1'b1, 1'b1, 6'd63);
    endtask

    task automatic test_table_full();
        send_job(1'b1, 1'b0, 1'b0, 6'd0);
        for (int i = 1; i < MAX_BATCHES; i++) begin
            send_job(1'b0, 1'b0, 1'b1, 6'($urandom_range(0, 63)));
        end
        send_job(1'b0, 1'b0, 1'b1, 6'd3);
        send_job(1'b0, 1'b1, 1'b0, 6'd0);
        send_job(1'b1, 1'b1, 1'b0, 6'd0);
    endtask

    task automatic test_parallel_off();
        set_parallel(1'b0);
        send_job(1'b1, 1'b1, 1'b1, 6'd7);
        send_job(1'b0, 1'b1, 1'b1, 6'd8);
        set_parallel(1'b1);
        send_job(1'b0, 1'b1, 1'b1, 6'd9);
        send_job(1'b0, 1'b1, 1'b0, 6'd0);
    endtask

    task automatic test_random_lists(int target);
        int sent;
        int list_len;
        int pool_base;
        int pool_size;
        int serial_pct;
        bit first;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 3) == 0) begin
                set_parallel(1'($urandom_range(0, 1)));
            end
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            list_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                    : $urandom_range(1, 16);
            pool_size = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 8);
            pool_base = $urandom_range(0, 63);
            serial_pct = $urandom_range(0, 40);
            for (int k = 0; k < list_len; k++) begin
                first = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
                send_job(first, $urandom_range(0, 99) >= serial_pct,
                         $urandom_range(0, 4) != 0,
                         6'(pool_base + $urandom_range(0, pool_size - 1)));
                sent++;
            end
            if ($urandom_range(0, 19) == 0) begin
                wait_for_results();
            end
        end
    endtask

    initial begin
        clear_table();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_first_fit_keys();
        test_table_full();
        test_parallel_off();
        test_random_lists(1400);
        wait_for_results();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
